[sv/assert_macros.svh]
// Assertion macros shared by the dashboard display RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dash_pkg.sv]
// Types and constants of the dashboard rpm and gear display.
package dash_pkg;

  localparam logic [10:0] ID_WARNING = 11'h5F4;
  localparam logic [10:0] ID_SPEED   = 11'h5F0;

  localparam int unsigned NUM_LEDS   = 12;
  localparam int unsigned NUM_GEARS  = 6;
  localparam int unsigned NUM_SHIFT  = 5;

  localparam logic [7:0]  SEG_NEUTRAL = 8'd238;

  // Standstill limit on wheel speed: at or below it the gear shows neutral.
  localparam logic [15:0] STANDSTILL_SPEED = 16'd5;

  // Shift window around the target rpm.
  localparam logic [16:0] SHIFT_WIN_BELOW = 17'd200;
  localparam logic [16:0] SHIFT_WIN_ABOVE = 17'd100;

  // Gear ratio is rpm*1.208 / (2.111*speed); compared as rpm*1208000
  // against band_thousandths*2111*speed.
  localparam int unsigned PROD_W    = 40;
  localparam logic [20:0] RATIO_NUM = 21'd1208000;
  localparam int unsigned RATIO_DEN = 2111;

  typedef logic [PROD_W-1:0] prod_t;

  // Bar thresholds: LED k (k >= 1) lights at rpm >= BAR_TH[k-1].
  localparam logic [15:0] BAR_TH [NUM_LEDS-1] = '{
    16'd2500, 16'd6000, 16'd7000, 16'd8000, 16'd9000, 16'd10000,
    16'd10500, 16'd11000, 16'd11500, 16'd12000, 16'd13000
  };

  // Band bounds already scaled by the ratio denominator.
  localparam logic [22:0] BAND_LO [NUM_GEARS] = '{
    23'(RATIO_DEN * 2383), 23'(RATIO_DEN * 1850), 23'(RATIO_DEN * 1567),
    23'(RATIO_DEN * 1394), 23'(RATIO_DEN * 1254), 23'(RATIO_DEN * 1158)
  };
  localparam logic [22:0] BAND_HI [NUM_GEARS] = '{
    23'(RATIO_DEN * 2783), 23'(RATIO_DEN * 2150), 23'(RATIO_DEN * 1767),
    23'(RATIO_DEN * 1494), 23'(RATIO_DEN * 1354), 23'(RATIO_DEN * 1253)
  };
  localparam logic [7:0]  BAND_SEG [NUM_GEARS] = '{
    8'd36, 8'd186, 8'd182, 8'd116, 8'd214, 8'd94
  };

  typedef enum logic [2:0] {
    CFG_SHIFT_G1    = 3'd0,
    CFG_SHIFT_G2    = 3'd1,
    CFG_SHIFT_G3    = 3'd2,
    CFG_SHIFT_G4    = 3'd3,
    CFG_SHIFT_G5    = 3'd4,
    CFG_OVER_REV    = 3'd5,
    CFG_OIL_LIMIT   = 3'd6,
    CFG_WATER_LIMIT = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] SHIFT_RESET [NUM_SHIFT] = '{
    16'd9500, 16'd12200, 16'd12100, 16'd12000, 16'd12000
  };
  localparam logic [15:0] OVER_REV_RESET    = 16'd13500;
  localparam logic [15:0] OIL_LIMIT_RESET   = 16'd50;
  localparam logic [15:0] WATER_LIMIT_RESET = 16'd70;
  localparam logic [15:0] TARGET_RESET      = 16'd9500;

endpackage

[sv/dashboard_rpm_gear_display.sv]
// Throughput: one frame per cycle while the output is not stalled; the frame register
// stores the sensor values, and the gear compare (two constant multiplies and two
// 40-bit compares per band) feeds the result register; both advance together
// whenever the result is free.
// Reset clears the stored values to zero, gear to neutral, target to 9500,
// registers to their defaults and both stages to empty.
`include "assert_macros.svh"

module dashboard_rpm_gear_display (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [10:0] frame_ident_i,
  input  logic [15:0] first_word_i,
  input  logic [15:0] second_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] rpm_bar_o,
  output logic        shift_flash_o,
  output logic [7:0]  gear_segments_o,
  output logic        oil_warning_o,
  output logic        water_warning_o
);

  // Configuration registers
  logic [15:0] shift_q [dash_pkg::NUM_SHIFT];
  logic [15:0] over_rev_q, oil_limit_q, water_limit_q;

  // Stored frame values (stage 1)
  logic        s1_valid_q, s1_valid_d;
  logic [15:0] rpm_q, rpm_d, speed_q, speed_d, temp_q, temp_d, oil_q, oil_d;

  // Gear state
  logic [15:0] target_q, target_d;
  logic [7:0]  gear_q, gear_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [11:0] bar_q, bar_d;
  logic        flash_q, flash_d, oil_warn_q, oil_warn_d, water_warn_q, water_warn_d;

  logic        advance, in_fire, s1_move;

  dash_pkg::prod_t num;
  dash_pkg::prod_t den_lo [dash_pkg::NUM_GEARS];
  dash_pkg::prod_t den_hi [dash_pkg::NUM_GEARS];
  logic [dash_pkg::NUM_GEARS-1:0] band_hit;
  logic [16:0] rpm_ext, tgt_ext;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_move    = s1_valid_q && advance;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dash_pkg::NUM_SHIFT; i++) begin
        shift_q[i] <= dash_pkg::SHIFT_RESET[i];
      end
      over_rev_q    <= dash_pkg::OVER_REV_RESET;
      oil_limit_q   <= dash_pkg::OIL_LIMIT_RESET;
      water_limit_q <= dash_pkg::WATER_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (dash_pkg::cfg_idx_e'(cfg_addr_i))
        dash_pkg::CFG_SHIFT_G1:    shift_q[0]    <= cfg_wdata_i;
        dash_pkg::CFG_SHIFT_G2:    shift_q[1]    <= cfg_wdata_i;
        dash_pkg::CFG_SHIFT_G3:    shift_q[2]    <= cfg_wdata_i;
        dash_pkg::CFG_SHIFT_G4:    shift_q[3]    <= cfg_wdata_i;
        dash_pkg::CFG_SHIFT_G5:    shift_q[4]    <= cfg_wdata_i;
        dash_pkg::CFG_OVER_REV:    over_rev_q    <= cfg_wdata_i;
        dash_pkg::CFG_OIL_LIMIT:   oil_limit_q   <= cfg_wdata_i;
        dash_pkg::CFG_WATER_LIMIT: water_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Store the frame into the sensor values it carries
  always_comb begin
    rpm_d   = rpm_q;
    speed_d = speed_q;
    temp_d  = temp_q;
    oil_d   = oil_q;
    if (in_fire) begin
      if (frame_ident_i == dash_pkg::ID_WARNING) begin
        temp_d = first_word_i;
        oil_d  = second_word_i;
      end else if (frame_ident_i == dash_pkg::ID_SPEED) begin
        rpm_d   = first_word_i;
        speed_d = second_word_i;
      end
    end
  end

  assign s1_valid_d  = in_fire || (s1_valid_q && !advance);
  assign out_valid_d = s1_move || (out_valid_q && !out_ready_i);

  // The shift window uses the target from before this frame's gear update
  assign rpm_ext = {1'b0, rpm_q};
  assign tgt_ext = {1'b0, target_q};

  always_comb begin
    bar_d    = '0;
    bar_d[0] = 1'b1;
    for (int k = 1; k < dash_pkg::NUM_LEDS; k++) begin
      bar_d[k] = rpm_q >= dash_pkg::BAR_TH[k-1];
    end
    if (rpm_q >= over_rev_q) begin
      bar_d = '0;
    end
  end

  assign flash_d = (rpm_ext + dash_pkg::SHIFT_WIN_BELOW > tgt_ext) &&
                   (rpm_ext < tgt_ext + dash_pkg::SHIFT_WIN_ABOVE);

  assign oil_warn_d   = oil_q > oil_limit_q;
  assign water_warn_d = temp_q > water_limit_q;

  // Gear bands by exact cross-multiplication
  assign num = dash_pkg::PROD_W'(rpm_q) * dash_pkg::PROD_W'(dash_pkg::RATIO_NUM);

  always_comb begin
    for (int g = 0; g < dash_pkg::NUM_GEARS; g++) begin
      den_lo[g]   = dash_pkg::PROD_W'(speed_q) * dash_pkg::PROD_W'(dash_pkg::BAND_LO[g]);
      den_hi[g]   = dash_pkg::PROD_W'(speed_q) * dash_pkg::PROD_W'(dash_pkg::BAND_HI[g]);
      band_hit[g] = (num > den_lo[g]) && (num <= den_hi[g]);
    end
  end

  // Bands are disjoint, so at most one hit; no hit keeps gear and target
  always_comb begin
    gear_d   = gear_q;
    target_d = target_q;
    if (speed_q <= dash_pkg::STANDSTILL_SPEED) begin
      gear_d = dash_pkg::SEG_NEUTRAL;
    end else begin
      for (int g = 0; g < dash_pkg::NUM_GEARS; g++) begin
        if (band_hit[g]) begin
          gear_d = dash_pkg::BAND_SEG[g];
        end
      end
      // sixth gear leaves the target alone
      for (int g = 0; g < dash_pkg::NUM_SHIFT; g++) begin
        if (band_hit[g]) begin
          target_d = shift_q[g];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rpm_q       <= '0;
      speed_q     <= '0;
      temp_q      <= '0;
      oil_q       <= '0;
      target_q    <= dash_pkg::TARGET_RESET;
      gear_q      <= dash_pkg::SEG_NEUTRAL;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      rpm_q       <= rpm_d;
      speed_q     <= speed_d;
      temp_q      <= temp_d;
      oil_q       <= oil_d;
      if (s1_move) begin
        target_q <= target_d;
        gear_q   <= gear_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      bar_q        <= bar_d;
      flash_q      <= flash_d;
      oil_warn_q   <= oil_warn_d;
      water_warn_q <= water_warn_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rpm_bar_o       = bar_q;
  assign shift_flash_o   = flash_q;
  assign gear_segments_o = gear_q;
  assign oil_warning_o   = oil_warn_q;
  assign water_warning_o = water_warn_q;

  `ASSERT_NEXT(a_standstill_neutral,
               s1_move && (speed_q <= dash_pkg::STANDSTILL_SPEED),
               gear_segments_o == dash_pkg::SEG_NEUTRAL, "standstill did not show neutral")
  `ASSERT_NEXT(a_over_rev_dark, s1_move && (rpm_q >= over_rev_q), rpm_bar_o == 12'd0,
               "bar lit at over rev")
  `ASSERT_IMPL(a_bar_thermometer, out_valid_o,
               ((13'(rpm_bar_o) + 13'd1) & 13'(rpm_bar_o)) == 13'd0,
               "bar is not a thermometer code")
  `ASSERT_NEXT(a_target_hold, !s1_move, $stable(target_q) && $stable(gear_q),
               "gear state moved without a request")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the dashboard rpm, gear and warning display.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NUM_REGS       = 8;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned RAND_PER_PHASE = 88;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam bit          TYPED          = 1'b1;
  localparam bit          PREDICT        = 1'b0;

  localparam logic [10:0] WARN_ID     = dash_pkg::ID_WARNING;
  localparam logic [10:0] SPEED_ID    = dash_pkg::ID_SPEED;
  localparam logic [7:0]  NEUTRAL_SEG = dash_pkg::SEG_NEUTRAL;

  // LED k lights from rpm BAR_STEPS[k-1] on; past the last step all twelve stay lit.
  localparam int unsigned BAR_STEPS [12] = '{
    2500, 6000, 7000, 8000, 9000, 10000, 10500, 11000, 11500, 12000, 13000, 14000
  };
  localparam int unsigned WINDOW_BELOW = 200;
  localparam int unsigned WINDOW_ABOVE = 100;

  // Gear ratio bands in thousandths, lower bound exclusive.
  localparam logic [63:0] RATIO_SCALE = 64'd1208000;
  localparam logic [63:0] RATIO_DIV   = 64'd2111;
  localparam logic [63:0] BAND_LO_MILLI [6] = '{2383, 1850, 1567, 1394, 1254, 1158};
  localparam logic [63:0] BAND_HI_MILLI [6] = '{2783, 2150, 1767, 1494, 1354, 1253};
  localparam logic [7:0]  GEAR_SEGS [6]     = '{8'd36, 8'd186, 8'd182, 8'd116, 8'd214, 8'd94};

  typedef struct packed {
    logic [10:0] ident;
    logic [15:0] word0;
    logic [15:0] word1;
  } frame_t;

  typedef struct packed {
    logic [11:0] bar;
    logic        flash;
    logic [7:0]  seg;
    logic        oil;
    logic        water;
  } display_t;

  typedef struct packed {
    frame_t   frame;
    bit       typed;
    display_t want;
  } row_t;

  typedef logic [NUM_REGS-1:0][15:0] settings_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [10:0] frame_ident = '0;
  logic [15:0] first_word = '0;
  logic [15:0] second_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] rpm_bar;
  logic        shift_flash;
  logic [7:0]  gear_segments;
  logic        oil_warning;
  logic        water_warning;

  // Predictor copy of registers and stored values
  logic [15:0] shift_rpm_cfg [5];
  logic [15:0] over_rev_cfg, oil_limit_cfg, water_limit_cfg;
  logic [15:0] seen_rpm, seen_speed, seen_coolant, seen_oil, shift_target;
  logic [7:0]  shown_gear;

  display_t    pending_displays [$];
  row_t        directed_rows [$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned displays_checked = 0;
  int unsigned speed_frames = 0, warning_frames = 0, other_frames = 0;
  int unsigned settings_loaded = 0;

  dashboard_rpm_gear_display dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .frame_ident_i   (frame_ident),
    .first_word_i    (first_word),
    .second_word_i   (second_word),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .rpm_bar_o       (rpm_bar),
    .shift_flash_o   (shift_flash),
    .gear_segments_o (gear_segments),
    .oil_warning_o   (oil_warning),
    .water_warning_o (water_warning)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_displays.size());
      $display("testbench failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  function automatic void reset_display_model();
    int i;
    for (i = 0; i < 5; i++) shift_rpm_cfg[i] = dash_pkg::SHIFT_RESET[i];
    over_rev_cfg    = dash_pkg::OVER_REV_RESET;
    oil_limit_cfg   = dash_pkg::OIL_LIMIT_RESET;
    water_limit_cfg = dash_pkg::WATER_LIMIT_RESET;
    seen_rpm        = '0;
    seen_speed      = '0;
    seen_coolant    = '0;
    seen_oil        = '0;
    shift_target    = dash_pkg::TARGET_RESET;
    shown_gear      = NEUTRAL_SEG;
  endfunction

  function automatic void apply_register(dash_pkg::cfg_idx_e idx, logic [15:0] value);
    case (idx)
      dash_pkg::CFG_SHIFT_G1:    shift_rpm_cfg[0] = value;
      dash_pkg::CFG_SHIFT_G2:    shift_rpm_cfg[1] = value;
      dash_pkg::CFG_SHIFT_G3:    shift_rpm_cfg[2] = value;
      dash_pkg::CFG_SHIFT_G4:    shift_rpm_cfg[3] = value;
      dash_pkg::CFG_SHIFT_G5:    shift_rpm_cfg[4] = value;
      dash_pkg::CFG_OVER_REV:    over_rev_cfg = value;
      dash_pkg::CFG_OIL_LIMIT:   oil_limit_cfg = value;
      dash_pkg::CFG_WATER_LIMIT: water_limit_cfg = value;
      default: ;
    endcase
  endfunction

  // Store the frame, then build the display from stored values and advance the gear.
  function automatic display_t compute_display(frame_t f);
    display_t    d;
    logic [31:0] rpm, tgt;
    logic [63:0] num, den;
    int          k, g;
    if (f.ident == WARN_ID) begin
      seen_coolant = f.word0;
      seen_oil     = f.word1;
    end else if (f.ident == SPEED_ID) begin
      seen_rpm   = f.word0;
      seen_speed = f.word1;
    end
    rpm = seen_rpm;
    tgt = shift_target;
    d.bar = 12'hFFF;
    for (k = 11; k >= 0; k--) begin
      if (rpm < BAR_STEPS[k]) d.bar = 12'((1 << (k + 1)) - 1);
    end
    if (rpm >= over_rev_cfg) d.bar = '0;
    d.flash = (rpm + WINDOW_BELOW > tgt) && (rpm < tgt + WINDOW_ABOVE);
    if (seen_speed <= dash_pkg::STANDSTILL_SPEED) begin
      shown_gear = NEUTRAL_SEG;
    end else begin
      num = 64'(seen_rpm) * RATIO_SCALE;
      den = 64'(seen_speed) * RATIO_DIV;
      for (g = 0; g < 6; g++) begin
        if (num > BAND_LO_MILLI[g] * den && num <= BAND_HI_MILLI[g] * den) begin
          shown_gear = GEAR_SEGS[g];
          if (g < 5) shift_target = shift_rpm_cfg[g];
        end
      end
    end
    d.seg   = shown_gear;
    d.oil   = seen_oil > oil_limit_cfg;
    d.water = seen_coolant > water_limit_cfg;
    return d;
  endfunction

  // Mostly plausible speed and warning frames; the rest is raw noise.
  function automatic frame_t next_random_frame();
    frame_t      f;
    int unsigned pick, ig_milli;
    logic [63:0] rpm64, speed64;
    pick    = $urandom_range(99, 0);
    f.ident = SPEED_ID;
    f.word0 = 16'($urandom);
    f.word1 = 16'($urandom);
    if (pick < 45) begin
      // aim at a ratio across all gear bands and the gaps between them
      rpm64 = ($urandom_range(9, 0) == 0) ? 64'($urandom_range(65535, 0))
                                          : 64'($urandom_range(15000, 0));
      ig_milli = $urandom_range(2850, 1100);
      speed64  = rpm64 * RATIO_SCALE / (64'(ig_milli) * RATIO_DIV);
      f.word0  = rpm64[15:0];
      f.word1  = (speed64 > 64'hFFFF) ? 16'hFFFF : speed64[15:0];
    end else if (pick < 55) begin
      // rpm around the shift window of the current target
      f.word0 = 16'(32'(shift_target) + $urandom_range(320, 0) - 210);
      f.word1 = ($urandom_range(1, 0) == 0) ? 16'($urandom_range(5, 0))
                                            : 16'($urandom_range(4000, 6));
    end else if (pick < 63) begin
      if ($urandom_range(1, 0) == 0) f.word1 = 16'($urandom_range(7, 0));
    end else if (pick < 88) begin
      f.ident = WARN_ID;
      if ($urandom_range(1, 0) == 0) begin
        f.word0 = 16'(32'(water_limit_cfg) + $urandom_range(2, 0) - 1);
        f.word1 = 16'(32'(oil_limit_cfg) + $urandom_range(2, 0) - 1);
      end
    end else begin
      f.ident = 11'($urandom_range(2047, 0));
    end
    return f;
  endfunction

  task automatic send_frame(frame_t f, bit typed, display_t want);
    display_t predicted;
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    frame_ident <= f.ident;
    first_word  <= f.word0;
    second_word <= f.word1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = compute_display(f);
    pending_displays.push_back(typed ? want : predicted);
    if (f.ident == SPEED_ID) speed_frames++;
    else if (f.ident == WARN_ID) warning_frames++;
    else other_frames++;
    @(negedge clk);
  endtask

  task automatic wait_for_displays();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_displays.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_settings(settings_t s);
    int i;
    for (i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= dash_pkg::cfg_idx_e'(i);
      cfg_wdata <= s[i];
      apply_register(dash_pkg::cfg_idx_e'(i), s[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic add_row(logic [10:0] ident, logic [15:0] w0, logic [15:0] w1, bit typed,
                         logic [11:0] bar, logic flash, logic [7:0] seg, logic oil,
                         logic water);
    row_t r;
    r.frame = {ident, w0, w1};
    r.typed = typed;
    r.want  = {bar, flash, seg, oil, water};
    directed_rows.push_back(r);
  endtask

  always @(posedge clk) begin : check_displays
    display_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {rpm_bar, shift_flash, gear_segments, oil_warning, water_warning};
      if (pending_displays.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: bar=%h flash=%b seg=%0d oil=%b water=%b",
                   cycle_count, got.bar, got.flash, got.seg, got.oil, got.water);
      end else begin
        want = pending_displays.pop_front();
        displays_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: expected bar=%h flash=%b seg=%0d oil=%b water=%b",
                     cycle_count, want.bar, want.flash, want.seg, want.oil, want.water);
            $display("  got bar=%h flash=%b seg=%0d oil=%b water=%b",
                     got.bar, got.flash, got.seg, got.oil, got.water);
          end
        end
      end
    end
  end

  initial begin
    settings_t   s;
    frame_t      f;
    int unsigned phase, n, i;

    reset_display_model();

    //       ident       rpm/temp   speed/oil  check    bar      flash seg          oil   water
    add_row(11'h000,     16'd0,     16'd0,     TYPED,   12'h001, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(11'h7FF,     16'hFFFF,  16'hFFFF,  TYPED,   12'h001, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(WARN_ID,     16'd70,    16'd50,    TYPED,   12'h001, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(WARN_ID,     16'd71,    16'd51,    TYPED,   12'h001, 1'b0, NEUTRAL_SEG, 1'b1, 1'b1);
    add_row(WARN_ID,     16'hFFFF,  16'hFFFF,  TYPED,   12'h001, 1'b0, NEUTRAL_SEG, 1'b1, 1'b1);
    add_row(WARN_ID,     16'd0,     16'd0,     TYPED,   12'h001, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'hFFFF,  16'd0,     TYPED,   12'h000, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd13499, 16'd5,     TYPED,   12'hFFF, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd13500, 16'hFFFF,  TYPED,   12'h000, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd2499,  16'd0,     TYPED,   12'h001, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd2500,  16'd0,     TYPED,   12'h003, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd9301,  16'd0,     TYPED,   12'h03F, 1'b1, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd9300,  16'd0,     TYPED,   12'h03F, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd9599,  16'd0,     TYPED,   12'h03F, 1'b1, NEUTRAL_SEG, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd9600,  16'd0,     TYPED,   12'h03F, 1'b0, NEUTRAL_SEG, 1'b0, 1'b0);
    // walk the gears one to six, then a ratio between the second and third band
    add_row(SPEED_ID,    16'd12236, 16'd2800,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd9800,  16'd2800,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd8064,  16'd2800,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd7084,  16'd2800,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd6356,  16'd2800,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd5880,  16'd2800,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(SPEED_ID,    16'd8820,  16'd2800,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);
    add_row(11'h5F1,     16'd12000, 16'd3000,  PREDICT, '0, 1'b0, '0, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 84; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 84; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase

      case (phase)
        0: begin
          foreach (directed_rows[i])
            send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);
        end
        1: load_settings('0);
        2: load_settings('1);
        3: begin
          for (i = 0; i < 5; i++) s[i] = 16'($urandom_range(14000, 8000));
          s[dash_pkg::CFG_OVER_REV]    = 16'($urandom_range(16000, 12000));
          s[dash_pkg::CFG_OIL_LIMIT]   = 16'($urandom_range(150, 20));
          s[dash_pkg::CFG_WATER_LIMIT] = 16'($urandom_range(150, 20));
          load_settings(s);
        end
        4: begin
          for (i = 0; i < NUM_REGS; i++) s[i] = 16'($urandom);
          load_settings(s);
        end
        default: begin
          for (i = 0; i < 5; i++) s[i] = dash_pkg::SHIFT_RESET[i];
          s[dash_pkg::CFG_OVER_REV]    = dash_pkg::OVER_REV_RESET;
          s[dash_pkg::CFG_OIL_LIMIT]   = dash_pkg::OIL_LIMIT_RESET;
          s[dash_pkg::CFG_WATER_LIMIT] = dash_pkg::WATER_LIMIT_RESET;
          load_settings(s);
        end
      endcase

      for (n = 0; n < RAND_PER_PHASE; n++) begin
        // hold off once mid-phase until the pipeline has fully drained
        if (phase == 3 && n == RAND_PER_PHASE / 2) wait_for_displays();
        f = next_random_frame();
        send_frame(f, PREDICT, '0);
      end
      wait_for_displays();
    end

    if (pending_displays.size() != 0) begin
      $display("%0d expected results never arrived", pending_displays.size());
      mismatch_count += pending_displays.size();
    end

    $display("Covered %0d frames (%0d speed, %0d warning, %0d other ids) over %0d settings",
             speed_frames + warning_frames + other_frames, speed_frames, warning_frames,
             other_frames, settings_loaded + 1);
    $display("Checked %0d display results, %0d mismatches", displays_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
